// ----- rtl/core/ndef_pkg.sv -----
// Shared types, codes and helpers for the NDEF record stream parser.
package ndef_pkg;

    // Byte roles as reported on the result channel
    localparam logic [2:0] ROLE_HEADER   = 3'd0;
    localparam logic [2:0] ROLE_TYPE_LEN = 3'd1;
    localparam logic [2:0] ROLE_PAY_LEN  = 3'd2;
    localparam logic [2:0] ROLE_ID_LEN   = 3'd3;
    localparam logic [2:0] ROLE_TYPE     = 3'd4;
    localparam logic [2:0] ROLE_ID       = 3'd5;
    localparam logic [2:0] ROLE_PAYLOAD  = 3'd6;
    localparam logic [2:0] ROLE_IGNORED  = 3'd7;

    // Parse status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Bit positions inside the 5-bit flag field (MB,ME,CF,SR,IL)
    localparam int FLAG_ME_BIT = 3;
    localparam int FLAG_SR_BIT = 1;
    localparam int FLAG_IL_BIT = 0;

    localparam logic [1:0] LONG_LEN_LAST = 2'd3;

    typedef enum logic [7:0] {
        PH_HDR  = 8'b0000_0001,
        PH_TLEN = 8'b0000_0010,
        PH_PLEN = 8'b0000_0100,
        PH_ILEN = 8'b0000_1000,
        PH_TYPE = 8'b0001_0000,
        PH_ID   = 8'b0010_0000,
        PH_PAY  = 8'b0100_0000,
        PH_IGN  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  flags;
        logic [2:0]  tnf;
        logic [7:0]  type_rem;
        logic [7:0]  id_rem;
        logic [31:0] pay_rem;
        logic [1:0]  len_cnt;
        logic [7:0]  records_seen;
    } parse_state_t;

    typedef struct packed {
        logic [2:0] byte_role;
        logic [7:0] byte_value;
        logic [2:0] record_number;
        logic [2:0] record_tnf;
        logic [4:0] record_flags;
        logic       record_done;
        logic       message_done;
        logic [1:0] parse_status;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_HDR,
        flags:        5'd0,
        tnf:          3'd0,
        type_rem:     8'd0,
        id_rem:       8'd0,
        pay_rem:      32'd0,
        len_cnt:      2'd0,
        records_seen: 8'd0
    };

    function automatic logic [2:0] phase_role(input phase_t ph);
        logic [2:0] r;
        case (ph)
            PH_HDR:  r = ROLE_HEADER;
            PH_TLEN: r = ROLE_TYPE_LEN;
            PH_PLEN: r = ROLE_PAY_LEN;
            PH_ILEN: r = ROLE_ID_LEN;
            PH_TYPE: r = ROLE_TYPE;
            PH_ID:   r = ROLE_ID;
            PH_PAY:  r = ROLE_PAYLOAD;
            default: r = ROLE_IGNORED;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/ndef_record_stream_parser.sv -----
// NDEF record stream parser top level: parse state, result register and skid stage.
//
// Takes an NDEF message one byte per transaction and returns one tagged byte
// per transaction: its role (header, type length, payload length, id length,
// type, id, payload or ignored), the byte itself, the record number (low 3
// bits of the count), the TNF and MB/ME/CF/SR/IL flags of the current record,
// record_done and message_done strobes, and a status (ok, too many records,
// buffer ended mid-record). Payload length is one byte with SR set, else four
// bytes most significant first; the id length byte appears only with IL set;
// empty type/id/payload sections are skipped. After the ME record the rest of the
// buffer is tagged ignored, as is a header beyond MAX_RECORDS records and all after it.
// s_last_byte marks the end of a buffer and returns the parser to its reset
// state. Throughput is one byte per clock while s_ready is high, and each result
// is registered: the parse state update is a registered loop (32-bit payload
// countdown plus section select), and a two-entry result buffer (output register
// plus skid register) keeps s_ready high while one result waits on m_ready.
module ndef_record_stream_parser #(
    parameter int MAX_RECORDS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_byte_role,
    output logic [7:0] m_byte_value,
    output logic [2:0] m_record_number,
    output logic [2:0] m_record_tnf,
    output logic [4:0] m_record_flags,
    output logic       m_record_done,
    output logic       m_message_done,
    output logic [1:0] m_parse_status
);
    import ndef_pkg::*;

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t step_res;

    parse_result_t out_reg;
    logic          out_valid_reg;
    parse_result_t skid_reg;
    logic          skid_valid_reg;

    logic          s_accept;
    logic          out_free;

    ndef_parse_step #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_step (
        .cur       (state_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .nxt       (state_next),
        .res       (step_res)
    );

    // Input is held off only when both result slots are occupied
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Parse state advances once per accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register with skid: a result that cannot go straight out parks
    // in the skid slot and moves forward when the output drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (s_accept) begin
                out_reg <= step_res;
            end
        end else if (s_accept) begin
            skid_reg <= step_res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_role     = out_reg.byte_role;
    assign m_byte_value    = out_reg.byte_value;
    assign m_record_number = out_reg.record_number;
    assign m_record_tnf    = out_reg.record_tnf;
    assign m_record_flags  = out_reg.record_flags;
    assign m_record_done   = out_reg.record_done;
    assign m_message_done  = out_reg.message_done;
    assign m_parse_status  = out_reg.parse_status;

endmodule

// ----- rtl/core/ndef_parse_step.sv -----
// Next-state and result logic for one byte of the NDEF stream.
module ndef_parse_step #(
    parameter int MAX_RECORDS = 8
) (
    input  ndef_pkg::parse_state_t  cur,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output ndef_pkg::parse_state_t  nxt,
    output ndef_pkg::parse_result_t res
);
    import ndef_pkg::*;

    localparam logic [7:0] MAX_REC = 8'(MAX_RECORDS);

    parse_state_t st;
    logic [2:0]   role;
    logic         body;
    phase_t       body_from;
    logic         body_found;
    phase_t       body_phase;
    logic         done;
    logic         mdone;
    logic [1:0]   status;

    always_comb begin
        st        = cur;
        role      = phase_role(cur.phase);
        body      = 1'b0;
        body_from = PH_TYPE;
        status    = STATUS_OK;

        case (cur.phase)
            PH_HDR: begin
                if (cur.records_seen >= MAX_REC) begin
                    role     = ROLE_IGNORED;
                    status   = STATUS_OVERFLOW;
                    st.phase = PH_IGN;
                end else begin
                    st.flags    = data_byte[7:3];
                    st.tnf      = data_byte[2:0];
                    st.type_rem = 8'd0;
                    st.id_rem   = 8'd0;
                    st.pay_rem  = 32'd0;
                    st.len_cnt  = 2'd0;
                    st.phase    = PH_TLEN;
                end
            end
            PH_TLEN: begin
                st.type_rem = data_byte;
                st.pay_rem  = 32'd0;
                st.len_cnt  = 2'd0;
                st.phase    = PH_PLEN;
            end
            PH_PLEN: begin
                st.pay_rem = {cur.pay_rem[23:0], data_byte};
                if (cur.flags[FLAG_SR_BIT] || cur.len_cnt == LONG_LEN_LAST) begin
                    st.len_cnt = 2'd0;
                    if (cur.flags[FLAG_IL_BIT]) begin
                        st.phase = PH_ILEN;
                    end else begin
                        body = 1'b1;
                    end
                end else begin
                    st.len_cnt = cur.len_cnt + 2'd1;
                end
            end
            PH_ILEN: begin
                st.id_rem = data_byte;
                body      = 1'b1;
            end
            PH_TYPE: begin
                if (cur.type_rem != 8'd0) begin
                    st.type_rem = cur.type_rem - 8'd1;
                end
                if (st.type_rem == 8'd0) begin
                    body      = 1'b1;
                    body_from = PH_ID;
                end
            end
            PH_ID: begin
                if (cur.id_rem != 8'd0) begin
                    st.id_rem = cur.id_rem - 8'd1;
                end
                if (st.id_rem == 8'd0) begin
                    body      = 1'b1;
                    body_from = PH_PAY;
                end
            end
            PH_PAY: begin
                if (cur.pay_rem != 32'd0) begin
                    st.pay_rem = cur.pay_rem - 32'd1;
                end
                if (st.pay_rem == 32'd0) begin
                    body      = 1'b1;
                    body_from = PH_PAY;
                end
            end
            default: begin
                role     = ROLE_IGNORED;
                st.phase = PH_IGN;
            end
        endcase

        // First non-empty section at or after body_from; empty ones are skipped
        body_found = 1'b1;
        if (body_from == PH_TYPE && st.type_rem != 8'd0) begin
            body_phase = PH_TYPE;
        end else if (body_from != PH_PAY && st.id_rem != 8'd0) begin
            body_phase = PH_ID;
        end else if (st.pay_rem != 32'd0) begin
            body_phase = PH_PAY;
        end else begin
            body_phase = PH_HDR;
            body_found = 1'b0;
        end

        done  = 1'b0;
        mdone = 1'b0;
        if (body) begin
            if (body_found) begin
                st.phase = body_phase;
            end else begin
                done = 1'b1;
                if (cur.records_seen != 8'hFF) begin
                    st.records_seen = cur.records_seen + 8'd1;
                end
                if (cur.flags[FLAG_ME_BIT]) begin
                    mdone    = 1'b1;
                    st.phase = PH_IGN;
                end else begin
                    st.phase = PH_HDR;
                end
            end
        end

        if (last_byte && role != ROLE_IGNORED && !done) begin
            status = STATUS_TRUNCATED;
        end

        res.byte_role    = role;
        res.byte_value   = data_byte;
        res.parse_status = status;
        if (role == ROLE_IGNORED) begin
            res.record_number = 3'd0;
            res.record_tnf    = 3'd0;
            res.record_flags  = 5'd0;
            res.record_done   = 1'b0;
            res.message_done  = 1'b0;
        end else begin
            res.record_number = cur.records_seen[2:0];
            res.record_tnf    = st.tnf;
            res.record_flags  = st.flags;
            res.record_done   = done;
            res.message_done  = mdone;
        end

        // End of buffer puts the parser back to a fresh message
        nxt = last_byte ? STATE_RESET : st;
    end

endmodule
